### rtl/rcfb_pkg.sv
// Package for the control frame builder: item types, frame constants
// and the hop channel tables. No dependencies.
`default_nettype none

package rcfb_pkg;

    typedef struct packed {
        logic               bind_req;
        logic signed [15:0] aileron;
        logic signed [15:0] elevator;
        logic signed [15:0] throttle;
        logic signed [15:0] rudder;
        logic signed [15:0] arm_switch;
        logic signed [15:0] led_switch;
        logic signed [15:0] flip_switch;
        logic signed [15:0] picture_switch;
        logic signed [15:0] video_switch;
        logic signed [15:0] angle_switch;
    } rcfb_req_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic [4:0] byte_index;
        logic       last_byte;
        logic       hop_now;
        logic [6:0] radio_channel;
    } rcfb_byte_t;

    // switch levels and frame kind, carried down the pipeline
    typedef struct packed {
        logic bind_frame;
        logic arm_level;
        logic led;
        logic flip;
        logic picture;
        logic video;
        logic angle;
    } rcfb_ctl_t;

    typedef struct packed {
        logic       hop_now;
        logic [6:0] radio_channel;
    } rcfb_hop_t;

    localparam logic [23:0] TX_ID_RESET  = 24'h909E4A;
    localparam logic [7:0]  CHK_SEED     = 8'h6D;
    localparam logic [7:0]  BIND_STICK   = 8'h7D;
    localparam logic [7:0]  AUX_BYTE     = 8'h20;
    localparam logic [7:0]  AUX_LAST     = 8'h40;
    localparam logic [7:0]  BIND_MODE    = 8'h60;
    localparam logic [7:0]  HOP_BIT      = 8'h40;
    localparam logic [7:0]  FLAG_BASE    = 8'h84;
    localparam logic [7:0]  FLIP_BIT     = 8'h08;
    localparam logic [7:0]  PICTURE_BIT  = 8'h01;
    localparam logic [7:0]  VIDEO_BIT    = 8'h02;
    localparam logic [7:0]  LED_BIT      = 8'h80;
    localparam logic [7:0]  ANGLE_BIT    = 8'h04;
    localparam logic [7:0]  ARM_BIT      = 8'h40;
    localparam logic [7:0]  DISARM_BIT   = 8'h20;
    localparam logic [7:0]  ARM_RESET    = 8'h20;
    localparam logic [8:0]  SCALE_TOP    = 9'd500;

    localparam logic [7:0] BIND_TABLE [16] = '{
        8'h1A, 8'h23, 8'h2C, 8'h35, 8'h3E, 8'h17, 8'h20, 8'h29,
        8'h32, 8'h3B, 8'h14, 8'h1D, 8'h26, 8'h2F, 8'h38, 8'h00
    };

    localparam logic [7:0] DATA_TABLE [16] = '{
        8'h12, 8'h20, 8'h2F, 8'h1A, 8'h28, 8'h38, 8'h14, 8'h23,
        8'h32, 8'h1C, 8'h2C, 8'h3B, 8'h17, 8'h26, 8'h34, 8'h00
    };

endpackage

`default_nettype wire

### rtl/rcfb_stick_scale.sv
// One stick channel: clamp, then scale to 0..500 in two registered stages
// (reciprocal multiply, then a one-step correction). Uses rcfb_pkg.
`default_nettype none

module rcfb_stick_scale #(
    parameter int CHAN_LOW  = -10000,
    parameter int CHAN_HIGH = 10000
) (
    input  wire logic               clk,
    input  wire logic signed [15:0] raw,
    input  wire logic               load_est,
    input  wire logic               load_fix,
    output logic [8:0]              scaled
);
    import rcfb_pkg::*;

    localparam int          SPAN   = CHAN_HIGH - CHAN_LOW;
    localparam logic [15:0] SPAN_W = 16'(SPAN);
    localparam logic [24:0] RECIP  = 25'((500 * 65536) / SPAN);
    localparam logic signed [16:0] LOW_S  = 17'(CHAN_LOW);
    localparam logic signed [16:0] HIGH_S = 17'(CHAN_HIGH);

    logic signed [16:0] raw_ext;
    logic signed [16:0] clamped;
    logic signed [16:0] offs;
    logic [15:0]        x;
    logic [40:0]        est_prod;
    logic [25:0]        fix_prod;
    logic [25:0]        num;
    logic [8:0]         est_inc;

    logic [15:0] x_reg;
    logic [8:0]  est_reg;
    logic [8:0]  scaled_reg;

    assign raw_ext = {raw[15], raw};

    always_comb
    begin
        if (raw_ext < LOW_S)
            clamped = LOW_S;
        else if (raw_ext > HIGH_S)
            clamped = HIGH_S;
        else
            clamped = raw_ext;
        offs     = clamped - LOW_S;
        x        = offs[15:0];
        est_prod = 41'(x) * 41'(RECIP);
    end

    // estimate is low by at most one
    assign est_inc  = 9'(est_reg + 9'd1);
    assign fix_prod = 26'(est_inc) * 26'(SPAN_W);
    assign num      = 26'(x_reg) * 26'(SCALE_TOP);

    always_ff @(posedge clk)
    begin
        if (load_est)
        begin
            x_reg   <= x;
            est_reg <= est_prod[24:16];
        end
        if (load_fix)
            scaled_reg <= (num >= fix_prod) ? est_inc : est_reg;
    end

    assign scaled = scaled_reg;

endmodule

`default_nettype wire

### rtl/rcfb_frame_build.sv
// Frame assembly and link state: arm toggles, hop bit, hop index, checksum.
// Registers one whole frame per load. Uses rcfb_pkg.
`default_nettype none

module rcfb_frame_build #(
    parameter int HOP_CHANNELS = 15,
    parameter int FRAME_BYTES  = 24
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        load,
    input  wire logic [23:0]                 tx_id,
    input  wire rcfb_pkg::rcfb_ctl_t         ctl,
    input  wire logic [8:0]                  ail,
    input  wire logic [8:0]                  ele,
    input  wire logic [8:0]                  thr,
    input  wire logic [8:0]                  rud,
    output logic [FRAME_BYTES-1:0][7:0]      frame,
    output rcfb_pkg::rcfb_hop_t              hop
);
    import rcfb_pkg::*;

    logic [7:0] prior_flag_reg;
    logic [7:0] prior_flag_next;
    logic [3:0] hop_idx_reg;
    logic [3:0] hop_idx_next;
    logic       arm_prior_reg;
    logic       arm_prior_next;
    logic [7:0] arm_toggle_reg;
    logic [7:0] arm_toggle_next;

    logic [FRAME_BYTES-1:0][7:0] frame_reg;
    logic [FRAME_BYTES-1:0][7:0] frame_next;
    rcfb_hop_t                   hop_reg;
    rcfb_hop_t                   hop_next;

    logic [7:0] chk;
    logic [4:0] hop_raw;
    logic [3:0] hop_wrap;

    always_comb
    begin
        arm_toggle_next = arm_toggle_reg;
        if (ctl.arm_level != arm_prior_reg)
            arm_toggle_next = arm_toggle_reg ^ (ctl.arm_level ? ARM_BIT : DISARM_BIT);
        arm_prior_next = ctl.arm_level;

        frame_next    = '0;
        frame_next[1] = tx_id[23:16];
        frame_next[2] = tx_id[15:8];
        frame_next[3] = tx_id[7:0];
        if (ctl.bind_frame)
        begin
            frame_next[4]  = 8'h00;
            frame_next[5]  = BIND_STICK;
            frame_next[6]  = BIND_STICK;
            frame_next[7]  = BIND_STICK;
            frame_next[8]  = AUX_BYTE;
            frame_next[9]  = AUX_BYTE;
            frame_next[10] = AUX_BYTE;
            frame_next[11] = AUX_LAST;
            frame_next[12] = prior_flag_reg ^ HOP_BIT;
            frame_next[13] = BIND_MODE;
        end
        else
        begin
            frame_next[4]  = thr[8:1];
            frame_next[5]  = rud[8:1];
            frame_next[6]  = ele[8:1];
            frame_next[7]  = ail[8:1];
            frame_next[8]  = AUX_BYTE | {ail[0], 7'd0};
            frame_next[9]  = AUX_BYTE | {ele[0], 7'd0};
            frame_next[10] = AUX_BYTE | {rud[0], 7'd0};
            frame_next[11] = AUX_LAST | {thr[0], 7'd0};
            frame_next[12] = FLAG_BASE
                           | ((prior_flag_reg & HOP_BIT) != 8'h00 ? 8'h00 : HOP_BIT)
                           | (ctl.flip    ? FLIP_BIT    : 8'h00)
                           | (ctl.picture ? PICTURE_BIT : 8'h00)
                           | (ctl.video   ? VIDEO_BIT   : 8'h00);
            frame_next[13] = arm_toggle_next
                           | (ctl.led   ? LED_BIT   : 8'h00)
                           | (ctl.angle ? ANGLE_BIT : 8'h00);
        end
        prior_flag_next = frame_next[12];

        chk = CHK_SEED;
        for (int i = 1; i < FRAME_BYTES; i++)
            chk = chk ^ frame_next[i];
        frame_next[0] = chk;

        hop_raw  = 5'({1'b0, hop_idx_reg}) + 5'd1;
        hop_wrap = (hop_raw >= 5'(HOP_CHANNELS)) ? 4'd0 : hop_raw[3:0];
        if ((frame_next[12] & HOP_BIT) == 8'h00)
        begin
            hop_idx_next          = hop_wrap;
            hop_next.hop_now      = 1'b1;
            hop_next.radio_channel = ctl.bind_frame ? BIND_TABLE[hop_wrap][6:0]
                                                    : DATA_TABLE[hop_wrap][6:0];
        end
        else
        begin
            hop_idx_next          = hop_idx_reg;
            hop_next.hop_now      = 1'b0;
            hop_next.radio_channel = 7'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prior_flag_reg <= 8'h00;
            hop_idx_reg    <= 4'd0;
            arm_prior_reg  <= 1'b0;
            arm_toggle_reg <= ARM_RESET;
        end
        else if (load)
        begin
            prior_flag_reg <= prior_flag_next;
            hop_idx_reg    <= hop_idx_next;
            arm_prior_reg  <= arm_prior_next;
            arm_toggle_reg <= arm_toggle_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            frame_reg <= frame_next;
            hop_reg   <= hop_next;
        end
    end

    assign frame = frame_reg;
    assign hop   = hop_reg;

endmodule

`default_nettype wire

### rtl/rcfb_serializer.sv
// Byte serializer: shifts one registered frame out one item per cycle
// while stall is low. Uses rcfb_pkg.
`default_nettype none

module rcfb_serializer #(
    parameter int FRAME_BYTES = 24
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        load,
    input  wire logic [FRAME_BYTES-1:0][7:0] frame,
    input  wire rcfb_pkg::rcfb_hop_t         hop,
    input  wire logic                        stall,
    output logic                             valid,
    output rcfb_pkg::rcfb_byte_t             item,
    output logic                             ready
);
    import rcfb_pkg::*;

    localparam logic [4:0] LAST_IDX = 5'(FRAME_BYTES - 1);

    logic                        busy_reg;
    logic                        busy_next;
    logic [4:0]                  idx_reg;
    logic [4:0]                  idx_next;
    logic [FRAME_BYTES-1:0][7:0] sh_reg;
    rcfb_hop_t                   hop_reg;
    logic                        take;
    logic                        last;

    assign last  = (idx_reg == LAST_IDX);
    assign take  = busy_reg && !stall;
    assign ready = !busy_reg || (take && last);

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (load)
        begin
            busy_next = 1'b1;
            idx_next  = 5'd0;
        end
        else if (take)
        begin
            if (last)
                busy_next = 1'b0;
            else
                idx_next = 5'(idx_reg + 5'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= 5'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sh_reg  <= frame;
            hop_reg <= hop;
        end
        else if (take)
            sh_reg <= sh_reg >> 8;
    end

    assign valid              = busy_reg;
    assign item.frame_byte    = sh_reg[0];
    assign item.byte_index    = idx_reg;
    assign item.last_byte     = last;
    assign item.hop_now       = hop_reg.hop_now;
    assign item.radio_channel = hop_reg.radio_channel;

endmodule

`default_nettype wire

### rtl/rc_control_frame_builder.sv
// Control frame builder top level: input register, stick scaling stages,
// frame assembly and byte serializer. Uses rcfb_pkg and the rcfb_* modules.
//
// Usage:
//   req channel (req_valid / req_stall / req) takes one item: a bind flag
//   and ten stick and switch values. Each item yields one frame of
//   FRAME_BYTES items on the fb channel (fb_valid / fb_stall / fb), byte 0
//   first, one item per cycle while fb_stall is low.
//   Path: byte 0 shows on fb once the req item has passed the input register,
//   scale estimate, scale correction, frame register and serializer load.
//   The serializer can load the next frame as the last byte is taken.
//   The pipeline holds up to four more items behind the frame being sent,
//   so req takes items in back-to-back cycles until those slots fill.
//   cfg_wr_en / cfg_wr_data write the 24-bit transmitter id; write it only
//   while no frame is pending.
//   Reset: pipeline empty, tx id 0x909E4A, hop index 0, disarm bit set.
//   When fb_stall is high the current item holds on fb and the stages
//   behind it fill up, then req_stall rises.
`default_nettype none

module rc_control_frame_builder #(
    parameter int CHAN_LOW     = -10000,
    parameter int CHAN_HIGH    = 10000,
    parameter int HOP_CHANNELS = 15,
    parameter int FRAME_BYTES  = 24
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wr_en,
    input  wire logic [23:0]          cfg_wr_data,
    input  wire logic                 req_valid,
    output logic                      req_stall,
    input  wire rcfb_pkg::rcfb_req_t  req,
    output logic                      fb_valid,
    input  wire logic                 fb_stall,
    output rcfb_pkg::rcfb_byte_t      fb
);
    import rcfb_pkg::*;

    logic [23:0] tx_id_reg;
    rcfb_req_t   req_reg;
    rcfb_ctl_t   ctl_b_reg;
    rcfb_ctl_t   ctl_c_reg;
    rcfb_ctl_t   ctl_b_next;

    logic va_reg, va_next;
    logic vb_reg, vb_next;
    logic vc_reg, vc_next;
    logic vf_reg, vf_next;

    logic accept;
    logic a_adv, b_adv, c_adv;
    logic a_free, b_free, c_free, f_free;
    logic ser_ready, ser_load;

    logic [8:0] ail_s, ele_s, thr_s, rud_s;
    logic [FRAME_BYTES-1:0][7:0] frame;
    rcfb_hop_t                   hop;

    // pipeline advance, back to front
    assign ser_load  = vf_reg && ser_ready;
    assign f_free    = !vf_reg || ser_load;
    assign c_adv     = vc_reg && f_free;
    assign c_free    = !vc_reg || c_adv;
    assign b_adv     = vb_reg && c_free;
    assign b_free    = !vb_reg || b_adv;
    assign a_adv     = va_reg && b_free;
    assign a_free    = !va_reg || a_adv;
    assign req_stall = !a_free;
    assign accept    = req_valid && a_free;

    always_comb
    begin
        va_next = accept ? 1'b1 : (a_adv ? 1'b0 : va_reg);
        vb_next = a_adv  ? 1'b1 : (b_adv ? 1'b0 : vb_reg);
        vc_next = b_adv  ? 1'b1 : (c_adv ? 1'b0 : vc_reg);
        vf_next = c_adv  ? 1'b1 : (ser_load ? 1'b0 : vf_reg);

        ctl_b_next.bind_frame = req_reg.bind_req;
        ctl_b_next.arm_level = !req_reg.arm_switch[15]     && (|req_reg.arm_switch);
        ctl_b_next.led       = !req_reg.led_switch[15]     && (|req_reg.led_switch);
        ctl_b_next.flip      = !req_reg.flip_switch[15]    && (|req_reg.flip_switch);
        ctl_b_next.picture   = !req_reg.picture_switch[15] && (|req_reg.picture_switch);
        ctl_b_next.video     = !req_reg.video_switch[15]   && (|req_reg.video_switch);
        ctl_b_next.angle     = !req_reg.angle_switch[15]   && (|req_reg.angle_switch);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg    <= 1'b0;
            vb_reg    <= 1'b0;
            vc_reg    <= 1'b0;
            vf_reg    <= 1'b0;
            tx_id_reg <= TX_ID_RESET;
        end
        else
        begin
            va_reg <= va_next;
            vb_reg <= vb_next;
            vc_reg <= vc_next;
            vf_reg <= vf_next;
            if (cfg_wr_en)
                tx_id_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            req_reg <= req;
        if (a_adv)
            ctl_b_reg <= ctl_b_next;
        if (b_adv)
            ctl_c_reg <= ctl_b_reg;
    end

    rcfb_stick_scale #(.CHAN_LOW(CHAN_LOW), .CHAN_HIGH(CHAN_HIGH)) u_ail (
        .clk      (clk),
        .raw      (req_reg.aileron),
        .load_est (a_adv),
        .load_fix (b_adv),
        .scaled   (ail_s)
    );

    rcfb_stick_scale #(.CHAN_LOW(CHAN_LOW), .CHAN_HIGH(CHAN_HIGH)) u_ele (
        .clk      (clk),
        .raw      (req_reg.elevator),
        .load_est (a_adv),
        .load_fix (b_adv),
        .scaled   (ele_s)
    );

    rcfb_stick_scale #(.CHAN_LOW(CHAN_LOW), .CHAN_HIGH(CHAN_HIGH)) u_thr (
        .clk      (clk),
        .raw      (req_reg.throttle),
        .load_est (a_adv),
        .load_fix (b_adv),
        .scaled   (thr_s)
    );

    rcfb_stick_scale #(.CHAN_LOW(CHAN_LOW), .CHAN_HIGH(CHAN_HIGH)) u_rud (
        .clk      (clk),
        .raw      (req_reg.rudder),
        .load_est (a_adv),
        .load_fix (b_adv),
        .scaled   (rud_s)
    );

    rcfb_frame_build #(.HOP_CHANNELS(HOP_CHANNELS), .FRAME_BYTES(FRAME_BYTES)) u_build (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (c_adv),
        .tx_id (tx_id_reg),
        .ctl   (ctl_c_reg),
        .ail   (ail_s),
        .ele   (ele_s),
        .thr   (thr_s),
        .rud   (rud_s),
        .frame (frame),
        .hop   (hop)
    );

    rcfb_serializer #(.FRAME_BYTES(FRAME_BYTES)) u_ser (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (ser_load),
        .frame (frame),
        .hop   (hop),
        .stall (fb_stall),
        .valid (fb_valid),
        .item  (fb),
        .ready (ser_ready)
    );

    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        fb_valid && fb.last_byte && !fb_stall |=> !fb_valid || fb.byte_index == 5'd0)
        else $error("frame did not restart at byte 0");

    a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
        fb_valid && !fb_stall && !fb.last_byte
        |=> fb_valid && fb.byte_index == 5'($past(fb.byte_index) + 5'd1))
        else $error("byte index skipped");

    a_hop_steady: assert property (@(posedge clk) disable iff (!rst_n)
        fb_valid && !fb.last_byte |=> $stable(fb.hop_now) && $stable(fb.radio_channel))
        else $error("hop fields changed inside a frame");

    a_no_hop_chan: assert property (@(posedge clk) disable iff (!rst_n)
        fb_valid && !fb.hop_now |-> fb.radio_channel == 7'd0)
        else $error("channel set without hop");

endmodule

`default_nettype wire
